FILE: rtl/npmg_pkg.sv
// ----------------------------------------------------------------------------
// npmg_pkg
// Shared types and constants for the nearest point match gate: command and
// status codes, beat structs for both channels, and reset defaults.
// ----------------------------------------------------------------------------
package npmg_pkg;

    // Default store depth and gate reset value ((5.0 px)^2 in Q26.8)
    localparam int          MAX_POINTS_DEF = 64;
    localparam int          GATE_W         = 34;
    localparam logic [33:0] GATE_RESET     = 34'd6400;
    localparam int          COORD_W        = 16;
    localparam int          INDEX_W        = 6;

    // Command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_MATCH = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_KEPT    = 2'd0;
    localparam logic [1:0] STATUS_DROPPED = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;

    // One stored reference point
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // Input beat
    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic [1:0]                status;
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
        logic signed [COORD_W-1:0] match_x;
        logic signed [COORD_W-1:0] match_y;
        logic [INDEX_W-1:0]        match_index;
    } res_t;

endpackage

FILE: rtl/nearest_point_match_gate_core.sv
// ----------------------------------------------------------------------------
// nearest_point_match_gate_core
// Keeps a store of reference points in a synchronous memory and, for each
// query, scans it for the nearest point by exact squared distance, then
// gates the pair against a programmable squared distance.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                        Direction  Beat
//  -------   -----------------------------  ---------  ----------------------
//  command   cmd_valid, cmd_ready, cmd_beat  in         clear / add / match
//  result    res_valid, res_ready, res_beat  out        one per match command
//  config    cfg_wr_en, cfg_wr_data          in         squared gate write
//
//  Clear, add and ignored codes are taken without leaving idle.
//  A match scans all N stored points: the scan reads one
//  point per cycle from the single-port point memory, through a four-stage
//  read / difference / square / compare pipeline.
//  A match on an empty store skips the scan and goes straight to finish.
//  Reset (rst_n low, asynchronous) empties the store and restores the gate;
//  the memory contents are not cleared and need no clearing pass.
//  A stalled result holds in the output register; clear and add beats are
//  still taken, and a finished match waits until that register is free.
// ----------------------------------------------------------------------------
module nearest_point_match_gate_core #(
    parameter int MAX_POINTS = npmg_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  npmg_pkg::cmd_t                  cmd_beat,
    output logic                            res_valid,
    input  logic                            res_ready,
    output npmg_pkg::res_t                  res_beat,
    input  logic                            cfg_wr_en,
    input  logic [npmg_pkg::GATE_W-1:0]     cfg_wr_data
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int DIF_W = npmg_pkg::COORD_W + 1;
    localparam int SQ_W  = 2 * npmg_pkg::COORD_W;
    localparam int D_W   = SQ_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Control state
    logic [1:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               rd_idx_reg;
    logic [npmg_pkg::GATE_W-1:0]    gate_reg;
    logic                           s0_v_reg, s1_v_reg, s2_v_reg;
    logic                           best_v_reg;
    logic                           res_valid_reg;

    // Payload state
    npmg_pkg::point_t               query_reg;
    npmg_pkg::point_t               rd_data_reg;
    npmg_pkg::point_t               s1_pt_reg, s2_pt_reg, best_pt_reg;
    logic [IDX_W-1:0]               s0_idx_reg, s1_idx_reg, s2_idx_reg, best_idx_reg;
    logic signed [DIF_W-1:0]        dx_reg, dy_reg;
    logic [SQ_W-1:0]                sqx_reg, sqy_reg;
    logic [D_W-1:0]                 best_d_reg;
    npmg_pkg::res_t                 res_reg;

    // Point memory
    npmg_pkg::point_t               mem [MAX_POINTS];

    logic                           accept;
    logic                           mem_we;
    logic                           mem_re;
    logic                           issue_more;
    logic                           scan_end;
    logic                           res_free;
    logic signed [2*DIF_W-1:0]      prod_x, prod_y;
    logic [D_W-1:0]                 dist_sum;
    npmg_pkg::point_t               wr_point;

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign accept     = cmd_valid && cmd_ready;
    assign issue_more = (rd_idx_reg < count_reg);
    assign mem_re     = (state_reg == ST_SCAN) && issue_more;
    assign mem_we     = accept && (cmd_beat.cmd == npmg_pkg::CMD_ADD)
                        && (count_reg < CNT_W'(MAX_POINTS));
    assign scan_end   = !issue_more && !s0_v_reg && !s1_v_reg && !s2_v_reg;
    assign res_free   = !res_valid_reg || res_ready;
    assign wr_point.x = cmd_beat.point_x;
    assign wr_point.y = cmd_beat.point_y;

    // Sequence commands: clear/add stay idle, scan then finish for match
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_beat.cmd)
                        npmg_pkg::CMD_CLEAR: count_next = '0;
                        npmg_pkg::CMD_ADD:
                        begin
                            if (mem_we)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        npmg_pkg::CMD_MATCH:
                        begin
                            state_next = (count_reg == '0) ? ST_DONE : ST_SCAN;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            gate_reg      <= npmg_pkg::GATE_RESET;
            s0_v_reg      <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            best_v_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                gate_reg <= cfg_wr_data;
            end
            // Restart the scan on any accepted beat, advance per read
            if (accept)
            begin
                rd_idx_reg <= '0;
                best_v_reg <= 1'b0;
            end
            else if (mem_re)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (s2_v_reg)
            begin
                best_v_reg <= 1'b1;
            end
            s0_v_reg <= mem_re;
            s1_v_reg <= s0_v_reg;
            s2_v_reg <= s1_v_reg;
            // Hold the result until taken
            if (state_reg == ST_DONE && res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Point memory: write on add, registered read during the scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= wr_point;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    assign prod_x   = dx_reg * dx_reg;
    assign prod_y   = dy_reg * dy_reg;
    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Scan pipeline: difference, square, compare against best
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= wr_point;
        end
        s0_idx_reg <= rd_idx_reg[IDX_W-1:0];
        s1_idx_reg <= s0_idx_reg;
        s2_idx_reg <= s1_idx_reg;
        s1_pt_reg  <= rd_data_reg;
        s2_pt_reg  <= s1_pt_reg;
        dx_reg     <= {rd_data_reg.x[15], rd_data_reg.x} - {query_reg.x[15], query_reg.x};
        dy_reg     <= {rd_data_reg.y[15], rd_data_reg.y} - {query_reg.y[15], query_reg.y};
        sqx_reg    <= prod_x[SQ_W-1:0];
        sqy_reg    <= prod_y[SQ_W-1:0];
        // Strict compare keeps the lower index on a tie
        if (s2_v_reg && (!best_v_reg || dist_sum < best_d_reg))
        begin
            best_d_reg   <= dist_sum;
            best_idx_reg <= s2_idx_reg;
            best_pt_reg  <= s2_pt_reg;
        end
        // Build the result beat
        if (state_reg == ST_DONE && res_free)
        begin
            res_reg.query_x <= query_reg.x;
            res_reg.query_y <= query_reg.y;
            if (count_reg == '0)
            begin
                res_reg.status      <= npmg_pkg::STATUS_EMPTY;
                res_reg.match_x     <= '0;
                res_reg.match_y     <= '0;
                res_reg.match_index <= '0;
            end
            else
            begin
                res_reg.status      <= ({1'b0, best_d_reg} < gate_reg) ?
                                       npmg_pkg::STATUS_KEPT : npmg_pkg::STATUS_DROPPED;
                res_reg.match_x     <= best_pt_reg.x;
                res_reg.match_y     <= best_pt_reg.y;
                res_reg.match_index <= npmg_pkg::INDEX_W'(best_idx_reg);
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_reg;

    // Pipeline beats only exist while scanning
    a_stage_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s0_v_reg || s1_v_reg || s2_v_reg) |-> (state_reg == ST_SCAN))
        else $error("scan pipeline active outside scan");

    // Store never grows past its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond depth");

    // A new result only comes out of the finish state
    a_res_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside finish");

    // Scan reads stay below the fill count
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (rd_idx_reg < count_reg) && !mem_we)
        else $error("read beyond stored points");

endmodule
